// ----- rtl/periodic_neighbor_pair_finder_top_macros.svh -----
// Assertion macros shared by the periodic neighbour pair finder RTL.
`ifndef PERIODIC_NEIGHBOR_PAIR_FINDER_TOP_MACROS_SVH
`define PERIODIC_NEIGHBOR_PAIR_FINDER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define PNPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pnpf assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define PNPF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pnpf assertion failed");
`else
`define PNPF_ASSERT_IMP(lbl, ante, cons)
`define PNPF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/pnpf_pkg.sv -----
// Shared constants, types and helpers of the periodic neighbour pair finder.
package pnpf_pkg;

  // Number formats
  localparam int COORD_BITS        = 20;
  localparam int FRAC_BITS         = 10;
  localparam int MAX_PERIODIC_DIMS = 3;
  localparam int RECIP_FRAC        = COORD_BITS - 2;
  localparam int PROJ_FRAC         = FRAC_BITS + RECIP_FRAC;

  // Register file
  localparam int NUM_REGS  = 8;
  localparam int REG_W     = 60;
  localparam int CFG_IDX_W = 3;
  localparam int IDX_W     = 16;
  localparam int CUT_W     = 20;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_A  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_C  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_A = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_B = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_C = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MISC    = 3'd7;

  // Datapath widths
  localparam int D_W    = COORD_BITS + 1;          // corrected difference
  localparam int PROD_W = COORD_BITS + D_W;        // projection product
  localparam int SUM_W  = PROD_W + 2;              // projection sum
  localparam int N_W    = SUM_W - PROJ_FRAC;       // rounded cell count
  localparam int Q_W    = N_W + COORD_BITS;        // count times cell vector
  localparam int E_W    = D_W + 2;                 // image vector component
  localparam int SQ_W   = 2 * COORD_BITS;          // squared component
  localparam int SS_W   = SQ_W + 2;                // squared length
  localparam int ROOT_W = (SS_W + 1) / 2;

  // Square root pipeline shape
  localparam int SQ_PER_STAGE = 3;
  localparam int SQ_STAGES    = (ROOT_W + SQ_PER_STAGE - 1) / SQ_PER_STAGE;
  localparam int SQ_ROOT_W    = SQ_STAGES * SQ_PER_STAGE;
  localparam int SQ_X_W       = 2 * SQ_ROOT_W;
  localparam int SQ_REM_W     = SQ_ROOT_W + 3;

  // Queue depths
  localparam int IQ_DEPTH = 2;
  localparam int OF_DEPTH = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [D_W-1:0]        diff_t;
  typedef logic signed [1:0]            img_t;

  // Saturation limits
  localparam diff_t  D_LIM  = {1'b0, {COORD_BITS{1'b1}}};
  localparam diff_t  D_NLIM = {1'b1, {(COORD_BITS - 1){1'b0}}, 1'b1};
  localparam coord_t C_MAX  = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam coord_t C_MIN  = {1'b1, {(COORD_BITS - 1){1'b0}}};
  localparam logic signed [SUM_W-1:0] ROUND_BIAS =
    {{(SUM_W - PROJ_FRAC + 1){1'b0}}, {(PROJ_FRAC - 1){1'b1}}};

  typedef struct packed {
    coord_t [2:0]      center;
    coord_t [2:0][2:0] cvec;    // [direction][component]
    coord_t [2:0][2:0] recip;   // [direction][component]
    logic [CUT_W-1:0]  cutoff;
    logic [1:0]        ndims;
    logic [2:0]        reach;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    diff_t [2:0]      d;
    logic [2:0]       reach;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    coord_t [2:0]     delta;
    img_t [2:0]       img;
    logic             near;
    logic             last;
    logic             over;
  } pay_t;

  typedef struct packed {
    logic [IDX_W-1:0]      index;
    logic [COORD_BITS-1:0] len;
    coord_t [2:0]          delta;
    img_t [2:0]            img;
    logic                  near;
    logic                  last;
  } rec_t;

  // Signed field k of a packed vector register; fields past bit 63 read as 0
  function automatic coord_t vfield(input logic [REG_W-1:0] r, input int k);
    logic [63+COORD_BITS:0] ext;
    ext = {{(COORD_BITS + 64 - REG_W){1'b0}}, r};
    if (k * COORD_BITS >= 64) return '0;
    return coord_t'(ext >> (k * COORD_BITS));
  endfunction

endpackage

// ----- rtl/pnpf_front.sv -----
// Front end: input beat holding, difference and minimum-image correction.
module pnpf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  pnpf_pkg::cfg_t                cfg,
  input  logic                          push,
  output logic                          full,
  input  logic [pnpf_pkg::IDX_W-1:0]    atom_index,
  input  logic signed [pnpf_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [pnpf_pkg::COORD_BITS-1:0] pos_y,
  input  logic signed [pnpf_pkg::COORD_BITS-1:0] pos_z,
  output logic                          item_valid,
  input  logic                          item_ready,
  output pnpf_pkg::item_t               item
);
  import pnpf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PROJ, S_ROUND, S_SCALE, S_UPDATE, S_PUSH
  } state_t;

  state_t state;
  logic   hold_valid;
  logic [IDX_W-1:0] hold_idx;
  coord_t [2:0]     hold_pos;
  logic [IDX_W-1:0] idx;
  diff_t [2:0]      d;
  logic [1:0]       dir;
  logic signed [PROD_W-1:0] prod [3];
  logic signed [N_W-1:0]    n;
  logic signed [Q_W-1:0]    q [3];
  logic signed [SUM_W-1:0]  s_sum;
  logic signed [N_W-1:0]    n_next;
  diff_t [2:0]              d_next;
  logic signed [Q_W:0]      t [3];

  assign full = hold_valid;

  // Hold one input beat while the correction of the previous one runs
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (push && !full) begin
      hold_valid <= 1'b1;
    end else if (state == S_IDLE) begin
      hold_valid <= 1'b0;
    end
    if (push && !full) begin
      hold_idx <= atom_index;
      hold_pos <= {pos_z, pos_y, pos_x};
    end
  end

  // Round the projection: ceil(p - 0.5)
  always_comb begin
    s_sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]) + ROUND_BIAS;
    n_next = N_W'(s_sum >>> PROJ_FRAC);
  end

  // Subtract the cell vector count and saturate
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      t[j] = (Q_W + 1)'($signed(d[j])) - (Q_W + 1)'(q[j]);
      if (t[j] > D_LIM) d_next[j] = D_LIM;
      else if (t[j] < D_NLIM) d_next[j] = D_NLIM;
      else d_next[j] = D_W'(t[j]);
    end
  end

  // Sequence the active directions
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (hold_valid) begin
            idx <= hold_idx;
            for (int j = 0; j < 3; j++)
              d[j] <= D_W'(cfg.center[j]) - D_W'(hold_pos[j]);
            dir   <= 2'd0;
            state <= (cfg.ndims == 2'd0) ? S_PUSH : S_PROJ;
          end
        end
        S_PROJ: begin
          for (int j = 0; j < 3; j++)
            prod[j] <= PROD_W'(cfg.recip[dir][j]) * PROD_W'($signed(d[j]));
          state <= S_ROUND;
        end
        S_ROUND: begin
          n     <= n_next;
          state <= S_SCALE;
        end
        S_SCALE: begin
          for (int j = 0; j < 3; j++)
            q[j] <= Q_W'(n) * Q_W'(cfg.cvec[dir][j]);
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          d     <= d_next;
          dir   <= dir + 2'd1;
          state <= (dir + 2'd1 == cfg.ndims) ? S_PUSH : S_PROJ;
        end
        S_PUSH: begin
          if (item_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item_valid = (state == S_PUSH);
  assign item.index = idx;
  assign item.d     = d;
  assign item.reach = cfg.reach;

endmodule

// ----- rtl/pnpf_sqrt.sv -----
// Pipelined integer square root, a few root bits per stage, payload carried.
module pnpf_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [pnpf_pkg::SS_W-1:0]     in_x,
  input  pnpf_pkg::pay_t                in_pay,
  output logic                          out_valid,
  output logic [pnpf_pkg::SQ_ROOT_W-1:0] out_root,
  output pnpf_pkg::pay_t                out_pay
);
  import pnpf_pkg::*;

  logic                 v_q    [SQ_STAGES+1];
  logic [SQ_X_W-1:0]    x_q    [SQ_STAGES+1];
  logic [SQ_REM_W-1:0]  rem_q  [SQ_STAGES+1];
  logic [SQ_ROOT_W-1:0] root_q [SQ_STAGES+1];
  pay_t                 pay_q  [SQ_STAGES+1];

  // Stage zero is the input itself
  assign v_q[0]    = in_valid;
  assign x_q[0]    = SQ_X_W'(in_x);
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign pay_q[0]  = in_pay;

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
    logic [SQ_X_W-1:0]    xw;
    logic [SQ_REM_W-1:0]  remw;
    logic [SQ_REM_W-1:0]  trialw;
    logic [SQ_ROOT_W-1:0] rootw;

    // Resolve SQ_PER_STAGE root bits, two radicand bits each
    always_comb begin
      xw     = x_q[k];
      remw   = rem_q[k];
      rootw  = root_q[k];
      trialw = '0;
      for (int s = 0; s < SQ_PER_STAGE; s++) begin
        remw   = {remw[SQ_REM_W-3:0], xw[SQ_X_W-1 -: 2]};
        xw     = {xw[SQ_X_W-3:0], 2'b00};
        trialw = {1'b0, rootw, 2'b01};
        if (remw >= trialw) begin
          remw  = remw - trialw;
          rootw = {rootw[SQ_ROOT_W-2:0], 1'b1};
        end else begin
          rootw = {rootw[SQ_ROOT_W-2:0], 1'b0};
        end
      end
    end

    // Advance the stage when the back end moves
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= v_q[k];
      end
      if (en) begin
        x_q[k+1]    <= xw;
        rem_q[k+1]  <= remw;
        root_q[k+1] <= rootw;
        pay_q[k+1]  <= pay_q[k];
      end
    end
  end

  assign out_valid = v_q[SQ_STAGES];
  assign out_root  = root_q[SQ_STAGES];
  assign out_pay   = pay_q[SQ_STAGES];

endmodule

// ----- rtl/pnpf_back.sv -----
// Back end: image walk, image vectors, length, cutoff test and result queue.
module pnpf_back (
  input  logic            clk,
  input  logic            rst,
  input  pnpf_pkg::cfg_t  cfg,
  input  logic            item_valid,
  output logic            item_ready,
  input  pnpf_pkg::item_t item,
  output logic            empty,
  input  logic            pop,
  output pnpf_pkg::rec_t  rec
);
  import pnpf_pkg::*;

  // Signed contribution of one cell vector for image offset r
  function automatic logic signed [E_W-1:0] img_term(input img_t r, input coord_t v);
    case (r)
      2'sb01:  return E_W'(v);
      2'sb11:  return -E_W'(v);
      default: return '0;
    endcase
  endfunction

  logic       en;
  logic       load;
  logic       cur_valid;
  item_t      cur;
  img_t [2:0] r;
  img_t [2:0] rc;
  logic       cur_last;

  logic signed [E_W-1:0] e [3];
  logic signed [E_W-1:0] mag [3];
  logic [2:0]            over_c;
  pay_t                  pay_c;
  logic [COORD_BITS-1:0] m_c [3];

  logic                  e1_valid;
  pay_t                  e1_pay;
  logic [COORD_BITS-1:0] e1_m [3];
  logic                  e2_valid;
  pay_t                  e2_pay;
  logic [SQ_W-1:0]       e2_sq [3];
  logic [2*CUT_W-1:0]    e2_cut2;
  logic [SS_W-1:0]       sum_c;
  pay_t                  e2_fin;
  logic                  e3_valid;
  pay_t                  e3_pay;
  logic [SS_W-1:0]       e3_sum;

  logic                  sq_valid;
  logic [SQ_ROOT_W-1:0]  sq_root;
  pay_t                  sq_pay;
  rec_t                  rec_c;

  rec_t        of_mem [OF_DEPTH];
  logic [1:0]  of_wptr;
  logic [1:0]  of_rptr;
  logic [2:0]  of_count;
  logic        of_full;
  logic        of_wr;
  logic        of_rd;

  assign of_full = (of_count == 3'(OF_DEPTH));
  assign en      = !of_full;

  // Walker: current item and image offsets
  for (genvar j = 0; j < 3; j++) begin : g_rc
    assign rc[j] = {1'b0, cur.reach[j]};
  end
  assign cur_last   = (r[0] == rc[0]) && (r[1] == rc[1]) && (r[2] == rc[2]);
  assign load       = en && (!cur_valid || cur_last);
  assign item_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (load) begin
      cur_valid <= item_valid;
    end
    if (load) begin
      cur <= item;
      for (int j = 0; j < 3; j++)
        r[j] <= -img_t'({1'b0, item.reach[j]});
    end else if (en && cur_valid) begin
      if (r[0] != rc[0]) begin
        r[0] <= r[0] + 2'sd1;
      end else begin
        r[0] <= -rc[0];
        if (r[1] != rc[1]) begin
          r[1] <= r[1] + 2'sd1;
        end else begin
          r[1] <= -rc[1];
          r[2] <= r[2] + 2'sd1;
        end
      end
    end
  end

  // Image vector, range check and saturated components
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      e[j] = E_W'($signed(cur.d[j])) + img_term(r[0], cfg.cvec[0][j])
           + img_term(r[1], cfg.cvec[1][j]) + img_term(r[2], cfg.cvec[2][j]);
      over_c[j] = (e[j] > D_LIM) || (e[j] < D_NLIM);
      mag[j]    = (e[j] < 0) ? -e[j] : e[j];
      m_c[j]    = over_c[j] ? '0 : mag[j][COORD_BITS-1:0];
      if (e[j] > C_MAX) pay_c.delta[j] = C_MAX;
      else if (e[j] < C_MIN) pay_c.delta[j] = C_MIN;
      else pay_c.delta[j] = COORD_BITS'(e[j]);
    end
    pay_c.index = cur.index;
    pay_c.img   = r;
    pay_c.near  = 1'b0;
    pay_c.last  = cur_last;
    pay_c.over  = |over_c;
  end

  // Stage E1 holds the image vector, E2 the squares, E3 the squared length
  always_comb begin
    sum_c       = SS_W'(e2_sq[0]) + SS_W'(e2_sq[1]) + SS_W'(e2_sq[2]);
    e2_fin      = e2_pay;
    e2_fin.near = !e2_pay.over && (sum_c < SS_W'(e2_cut2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
      e2_valid <= 1'b0;
      e3_valid <= 1'b0;
    end else if (en) begin
      e1_valid <= cur_valid;
      e2_valid <= e1_valid;
      e3_valid <= e2_valid;
    end
    if (en) begin
      e1_pay <= pay_c;
      e1_m   <= m_c;
      e2_pay <= e1_pay;
      for (int j = 0; j < 3; j++)
        e2_sq[j] <= SQ_W'(e1_m[j]) * SQ_W'(e1_m[j]);
      e2_cut2 <= (2 * CUT_W)'(cfg.cutoff) * (2 * CUT_W)'(cfg.cutoff);
      e3_pay  <= e2_fin;
      e3_sum  <= sum_c;
    end
  end

  pnpf_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e3_valid),
    .in_x      (e3_sum),
    .in_pay    (e3_pay),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_pay   (sq_pay)
  );

  // Assemble the result beat
  always_comb begin
    rec_c.index = sq_pay.index;
    rec_c.delta = sq_pay.delta;
    rec_c.img   = sq_pay.img;
    rec_c.near  = sq_pay.near;
    rec_c.last  = sq_pay.last;
    if (sq_pay.over || (sq_root > SQ_ROOT_W'({COORD_BITS{1'b1}})))
      rec_c.len = {COORD_BITS{1'b1}};
    else
      rec_c.len = sq_root[COORD_BITS-1:0];
  end

  // Result queue
  assign of_wr = en && sq_valid;
  assign of_rd = pop && !empty;
  assign empty = (of_count == 3'd0);
  assign rec   = of_mem[of_rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      of_wptr  <= '0;
      of_rptr  <= '0;
      of_count <= '0;
    end else begin
      if (of_wr) of_wptr <= of_wptr + 2'd1;
      if (of_rd) of_rptr <= of_rptr + 2'd1;
      of_count <= of_count + 3'(of_wr) - 3'(of_rd);
    end
    if (of_wr) of_mem[of_wptr] <= rec_c;
  end

endmodule

// ----- rtl/periodic_neighbor_pair_finder_top.sv -----
// Top level of the periodic neighbour pair finder: registers, item queue, ends.
//
// Usage: write the eight registers through cfg_we/cfg_index/cfg_data while
// the block is idle. Each input beat (push while full is low) carries one
// other atom. The block forms centre minus position, applies the
// minimum-image correction along each active direction, then walks the
// image offsets (first direction fastest) and gives one result beat per
// image: offsets, image vector, length, cutoff flag and a last-image mark.
// Results wait in a four-beat queue; pop while empty is low takes one.
// The image walker issues one result a cycle while the result queue is not
// full and takes the next item after the last of its 1 to 27 images. The
// correction sequencer runs projection, rounding, scaling and update for
// each active direction and runs ahead through a two-entry item queue.
// When the receiver stalls, the whole back end holds once the result queue
// fills, then the item queue and the input fill in turn.
// Reset clears the eight configuration registers to zero and empties every queue.
`include "periodic_neighbor_pair_finder_top_macros.svh"
module periodic_neighbor_pair_finder_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [pnpf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pnpf_pkg::REG_W-1:0]              cfg_data,
  input  logic                                    push,
  output logic                                    full,
  input  logic [pnpf_pkg::IDX_W-1:0]              atom_index,
  input  logic signed [pnpf_pkg::COORD_BITS-1:0]  pos_x,
  input  logic signed [pnpf_pkg::COORD_BITS-1:0]  pos_y,
  input  logic signed [pnpf_pkg::COORD_BITS-1:0]  pos_z,
  output logic                                    empty,
  input  logic                                    pop,
  output logic [pnpf_pkg::IDX_W-1:0]              pair_index,
  output logic [pnpf_pkg::COORD_BITS-1:0]         distance,
  output logic signed [pnpf_pkg::COORD_BITS-1:0]  delta_x,
  output logic signed [pnpf_pkg::COORD_BITS-1:0]  delta_y,
  output logic signed [pnpf_pkg::COORD_BITS-1:0]  delta_z,
  output logic signed [1:0]                       image_a,
  output logic signed [1:0]                       image_b,
  output logic signed [1:0]                       image_c,
  output logic                                    within_cutoff,
  output logic                                    last_image
);
  import pnpf_pkg::*;

  logic [REG_W-1:0] regs [NUM_REGS];
  cfg_t             cfg;
  logic [REG_W-1:0] misc;

  logic  f_valid;
  logic  f_ready;
  item_t f_item;
  logic  b_valid;
  logic  b_ready;
  item_t b_item;
  rec_t  rec;

  item_t      iq_mem [IQ_DEPTH];
  logic       iq_wptr;
  logic       iq_rptr;
  logic [1:0] iq_count;
  logic       iq_wr;
  logic       iq_rd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) regs[i] <= '0;
    end else if (cfg_we) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // Unpack register fields
  assign misc = regs[REG_MISC];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cfg.center[j]   = vfield(regs[REG_CENTER], j);
      cfg.cvec[0][j]  = vfield(regs[REG_CELL_A], j);
      cfg.cvec[1][j]  = vfield(regs[REG_CELL_B], j);
      cfg.cvec[2][j]  = vfield(regs[REG_CELL_C], j);
      cfg.recip[0][j] = vfield(regs[REG_RECIP_A], j);
      cfg.recip[1][j] = vfield(regs[REG_RECIP_B], j);
      cfg.recip[2][j] = vfield(regs[REG_RECIP_C], j);
    end
    cfg.cutoff = misc[CUT_W-1:0];
    cfg.ndims  = (misc[33:32] > 2'(MAX_PERIODIC_DIMS)) ? 2'(MAX_PERIODIC_DIMS)
                                                       : misc[33:32];
    for (int i = 0; i < 3; i++)
      cfg.reach[i] = (2'(i) < cfg.ndims) && (misc[20 + 4 * i +: 4] != 4'd0);
  end

  pnpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .push       (push),
    .full       (full),
    .atom_index (atom_index),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  // Item queue between the front and back ends
  assign f_ready = (iq_count != 2'(IQ_DEPTH));
  assign iq_wr   = f_valid && f_ready;
  assign b_valid = (iq_count != 2'd0);
  assign iq_rd   = b_ready && b_valid;
  assign b_item  = iq_mem[iq_rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      iq_wptr  <= 1'b0;
      iq_rptr  <= 1'b0;
      iq_count <= 2'd0;
    end else begin
      if (iq_wr) iq_wptr <= ~iq_wptr;
      if (iq_rd) iq_rptr <= ~iq_rptr;
      iq_count <= iq_count + 2'(iq_wr) - 2'(iq_rd);
    end
    if (iq_wr) iq_mem[iq_wptr] <= f_item;
  end

  pnpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (b_valid),
    .item_ready (b_ready),
    .item       (b_item),
    .empty      (empty),
    .pop        (pop),
    .rec        (rec)
  );

  assign pair_index    = rec.index;
  assign distance      = rec.len;
  assign delta_x       = rec.delta[0];
  assign delta_y       = rec.delta[1];
  assign delta_z       = rec.delta[2];
  assign image_a       = rec.img[0];
  assign image_b       = rec.img[1];
  assign image_c       = rec.img[2];
  assign within_cutoff = rec.near;
  assign last_image    = rec.last;

  `PNPF_ASSERT_IMP(a_iq_bound, 1'b1, iq_count <= 2'(IQ_DEPTH))
  `PNPF_ASSERT_IMP(a_iq_ptrs, iq_count == 2'd1, iq_wptr != iq_rptr)
  `PNPF_ASSERT_NXT(a_accept_holds, push && !full, full)

endmodule
